>>> src/mbp_pkg.sv
package mbp_pkg;

  localparam int MAX_BITS_DEF = 32;
  localparam int VALUE_W      = 32;
  localparam int COUNT_W      = 6;
  localparam int BYTE_W       = 8;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_MERGE = 3'b010,
    ST_EMIT  = 3'b100
  } state_t;

  typedef struct packed {
    logic capture;
    logic merge;
    logic emit;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic more;
    logic last_byte;
    logic out_slot;
  } sts_t;

endpackage

>>> src/mbp_if.sv
interface mbp_in_if import mbp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               mode;
  logic [VALUE_W-1:0] value;
  logic [COUNT_W-1:0] bit_count;

  modport source (output valid, output mode, output value, output bit_count, input ready);
  modport sink   (input valid, input mode, input value, input bit_count, output ready);
endinterface

interface mbp_out_if import mbp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

>>> src/mbp_ctrl.sv
module mbp_ctrl import mbp_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  sts_t   sts,
  output cmd_t   cmd,
  output state_t state
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_MERGE;
        end
      end
      ST_MERGE: begin
        cmd.merge = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!sts.more) begin
          // fewer than eight bits left: keep them as the partial byte
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end else if (sts.out_slot) begin
          cmd.emit = 1'b1;
          if (sts.last_byte) begin
            cmd.commit = 1'b1;
            state_nxt  = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign state = state_r;

endmodule

>>> src/mbp_datapath.sv
module mbp_datapath import mbp_pkg::*; #(
  parameter int MAX_BITS = MAX_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic               in_mode,
  input  logic [VALUE_W-1:0] in_value,
  input  logic [COUNT_W-1:0] in_bit_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [BYTE_W-1:0]  out_byte,
  output logic               out_last
);

  localparam int VW   = MAX_BITS;
  localparam int SRW  = BYTE_W + VW;
  localparam int CW   = $clog2(MAX_BITS + 1);
  localparam int TW   = $clog2(BYTE_W + MAX_BITS);
  localparam int CMPW = (CW > COUNT_W) ? CW : COUNT_W;
  localparam int XW   = (VW > VALUE_W) ? VW : VALUE_W;

  logic               mode_r;
  logic [VALUE_W-1:0] value_r;
  logic [CW-1:0]      cnt_r;
  logic [CW-1:0]      cnt_nxt;

  logic [BYTE_W-1:0]  partial_r, partial_nxt;
  logic [2:0]         filled_r, filled_nxt;
  logic [SRW-1:0]     sr_r, sr_nxt;
  logic [TW-1:0]      total_r, total_nxt;

  logic               out_valid_r;
  logic [BYTE_W-1:0]  out_byte_r;
  logic               out_last_r;

  logic [XW-1:0]      vx;
  logic [VW-1:0]      field;
  logic [CW-1:0]      sh;
  logic [SRW-1:0]     sr_shift;
  logic [TW-1:0]      total_dec;

  // clamp the count on transfer
  always_comb begin
    if (CMPW'(in_bit_count) > CMPW'(MAX_BITS)) begin
      cnt_nxt = CW'(MAX_BITS);
    end else begin
      cnt_nxt = CW'(in_bit_count);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r  <= in_mode;
      value_r <= in_value;
      cnt_r   <= cnt_nxt;
    end
  end

  // left-align the new bits, then place them right behind the pending ones
  assign vx    = XW'(value_r);
  assign sh    = CW'(VW) - cnt_r;
  assign field = vx[VW-1:0] << sh;

  assign sr_shift  = sr_r << BYTE_W;
  assign total_dec = total_r - TW'(BYTE_W);

  always_comb begin
    sr_nxt    = sr_r;
    total_nxt = total_r;
    if (cmd.merge) begin
      if (mode_r) begin
        sr_nxt    = {partial_r, {VW{1'b0}}};
        total_nxt = (filled_r != 3'd0) ? TW'(BYTE_W) : '0;
      end else begin
        sr_nxt    = {partial_r, {VW{1'b0}}} | ({field, {BYTE_W{1'b0}}} >> filled_r);
        total_nxt = TW'(filled_r) + TW'(cnt_r);
      end
    end else if (cmd.emit) begin
      sr_nxt    = sr_shift;
      total_nxt = total_dec;
    end
  end

  always_ff @(posedge clk) begin
    sr_r    <= sr_nxt;
    total_r <= total_nxt;
  end

  always_comb begin
    partial_nxt = partial_r;
    filled_nxt  = filled_r;
    if (cmd.commit) begin
      if (cmd.emit) begin
        partial_nxt = sr_shift[SRW-1 -: BYTE_W];
        filled_nxt  = total_dec[2:0];
      end else begin
        partial_nxt = sr_r[SRW-1 -: BYTE_W];
        filled_nxt  = total_r[2:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      filled_r  <= '0;
    end else begin
      partial_r <= partial_nxt;
      filled_r  <= filled_nxt;
    end
  end

  // output register: hold until transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte_r <= sr_r[SRW-1 -: BYTE_W];
      out_last_r <= sts.last_byte;
    end
  end

  assign sts.more      = (total_r >= TW'(BYTE_W));
  assign sts.last_byte = ({1'b0, total_r} < (TW + 1)'(2 * BYTE_W));
  assign sts.out_slot  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule

>>> src/msb_first_bit_packer_top.sv
// After an input transfer the item is merged in MERGE; EMIT loads its bytes into the
// output register. A write item yields N output bytes (N up to 4 at MAX_BITS = 32)
// or none; an align item yields one byte if bits are pending. The single output
// register moves one byte per cycle while the sink is ready; items enter only in IDLE.
// Reset (synchronous, active low) clears the partial byte, its fill count,
// the controller state and the output valid.
module msb_first_bit_packer_top import mbp_pkg::*; #(
  parameter int MAX_BITS = MAX_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  mbp_in_if.sink   in_ch,
  mbp_out_if.source out_ch
);

  cmd_t   cmd;
  sts_t   sts;
  state_t state;

  mbp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd),
    .state    (state)
  );

  mbp_datapath #(
    .MAX_BITS (MAX_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_mode      (in_ch.mode),
    .in_value     (in_ch.value),
    .in_bit_count (in_ch.bit_count),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_byte     (out_ch.out_byte),
    .out_last     (out_ch.last)
  );

  a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (sts.more && sts.out_slot))
    else $error("byte emitted without eight bits or without output room");

  a_commit_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> (state == ST_IDLE))
    else $error("partial byte committed but controller not idle");

  a_merge_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.merge |-> $past(in_ch.valid && in_ch.ready))
    else $error("merge without a preceding input transfer");

  a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_ch.valid)
    else $error("emitted byte not presented at output");

endmodule

>>> tb/sv/msb_first_bit_packer_top_test.sv
module msb_first_bit_packer_top_test import mbp_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_ALIGN = 1'b1;

  // Sink ready patterns
  localparam int SINK_FREE  = 0;
  localparam int SINK_MIXED = 1;
  localparam int SINK_HEAVY = 2;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } byte_exp_t;

  class byte_scoreboard;
    logic [BYTE_W-1:0] acc_byte;
    int unsigned       acc_bits;
    byte_exp_t         pending_bytes[$];
    int unsigned       errors;
    int unsigned       bytes_checked;

    function new();
      acc_byte      = '0;
      acc_bits      = 0;
      errors        = 0;
      bytes_checked = 0;
    endfunction

    // Append one expected byte at the tail.
    function void queue_byte(logic [BYTE_W-1:0] d, logic l);
      byte_exp_t e;
      e.data = d;
      e.last = l;
      pending_bytes = {pending_bytes, e};
    endfunction

    // Pack one accepted item and queue the bytes it completes.
    function void note_input(logic m, logic [VALUE_W-1:0] v, logic [COUNT_W-1:0] c);
      int unsigned nbits;
      int unsigned emitted;
      logic        b;
      emitted = 0;
      if (m == MODE_ALIGN) begin
        if (acc_bits != 0) begin
          queue_byte(acc_byte, 1'b1);
          acc_byte = '0;
          acc_bits = 0;
        end
        return;
      end
      nbits = (int'(c) > MAX_BITS_DEF) ? MAX_BITS_DEF : int'(c);
      for (int i = int'(nbits) - 1; i >= 0; i--) begin
        b = (i < VALUE_W) ? v[i] : 1'b0;
        acc_byte[7 - acc_bits] = b;
        acc_bits++;
        if (acc_bits == BYTE_W) begin
          queue_byte(acc_byte, 1'b0);
          acc_byte = '0;
          acc_bits = 0;
          emitted++;
        end
      end
      if (emitted > 0)
        pending_bytes[pending_bytes.size() - 1].last = 1'b1;
    endfunction

    function void check_byte(logic [BYTE_W-1:0] data, logic last);
      byte_exp_t e;
      if (pending_bytes.size() == 0) begin
        $error("out_byte 0x%02h (last %0b) arrived with no byte expected", data, last);
        errors++;
        return;
      end
      e = pending_bytes.pop_front();
      bytes_checked++;
      if (data !== e.data) begin
        $error("out_byte: expected 0x%02h, actual 0x%02h", e.data, data);
        errors++;
      end
      if (last !== e.last) begin
        $error("last: expected %0b, actual %0b", e.last, last);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return pending_bytes.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  mbp_in_if  in_ch();
  mbp_out_if out_ch();

  msb_first_bit_packer_top #(
    .MAX_BITS(MAX_BITS_DEF)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  byte_scoreboard sb;
  bit             in_idle;
  int             sink_mode;
  int unsigned    n_writes, n_aligns, n_clamped, n_empty, n_idle_aligns;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60)
      return 0;
    else if (r < 90)
      return $urandom_range(1, 3);
    else
      return $urandom_range(5, 20);
  endfunction

  task automatic send_item(input logic m, input logic [VALUE_W-1:0] v,
                           input logic [COUNT_W-1:0] c);
    int gap;
    gap = in_idle ? gap_len() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= m;
    in_ch.value     <= v;
    in_ch.bit_count <= c;
    do @(posedge clk); while (!in_ch.ready);
    if (m == MODE_ALIGN) begin
      n_aligns++;
      if (sb.acc_bits == 0)
        n_idle_aligns++;
    end else begin
      n_writes++;
      if (c > MAX_BITS_DEF)
        n_clamped++;
      if (c == 0)
        n_empty++;
    end
    sb.note_input(m, v, c);
  endtask

  // Drop valid and hold until the output side has drained.
  task automatic drain_output(input int extra);
    in_ch.valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic sink_loop();
    int   stall_left;
    logic rdy;
    stall_left = 0;
    forever begin
      if (stall_left > 0) begin
        rdy = 1'b0;
        stall_left--;
      end else begin
        rdy = 1'b1;
        if (sink_mode == SINK_MIXED && $urandom_range(0, 3) == 0)
          stall_left = gap_len();
        else if (sink_mode == SINK_HEAVY && $urandom_range(0, 1) == 0)
          stall_left = gap_len() + $urandom_range(1, 4);
      end
      out_ch.ready <= rdy;
      @(posedge clk);
      if (out_ch.valid && out_ch.ready)
        sb.check_byte(out_ch.out_byte, out_ch.last);
    end
  endtask

  function automatic logic [COUNT_W-1:0] random_count();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8)
      return '0;
    else if (r < 55)
      return COUNT_W'($urandom_range(1, 8));
    else if (r < 85)
      return COUNT_W'($urandom_range(9, 32));
    else
      return COUNT_W'($urandom_range(33, 63));
  endfunction

  task automatic random_phase(input int items, input bit idle_on, input int smode);
    int unsigned target;
    logic        m;
    in_idle   = idle_on;
    sink_mode = smode;
    target    = n_writes + n_aligns + items;
    while (n_writes + n_aligns < target) begin
      m = ($urandom_range(0, 99) < 20) ? MODE_ALIGN : MODE_WRITE;
      send_item(m, $urandom, random_count());
    end
  endtask

  initial begin
    sb = new();
    n_writes = 0; n_aligns = 0; n_clamped = 0;
    n_empty = 0; n_idle_aligns = 0;
    in_idle   = 1'b1;
    sink_mode = SINK_MIXED;

    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.mode      <= MODE_WRITE;
    in_ch.value     <= '0;
    in_ch.bit_count <= '0;
    out_ch.ready    <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    fork
      sink_loop();
    join_none

    // Directed: extremes, clamping, empty writes, flushes with and without pending bits
    send_item(MODE_ALIGN, 32'h0000_0000, 6'd0);
    send_item(MODE_WRITE, 32'hFFFF_FFFF, 6'd0);
    send_item(MODE_WRITE, 32'hFFFF_FFFF, 6'd32);
    send_item(MODE_WRITE, 32'h1234_5678, 6'd63);
    send_item(MODE_WRITE, 32'h0000_0000, 6'd33);
    send_item(MODE_WRITE, 32'h0000_0001, 6'd1);
    send_item(MODE_ALIGN, 32'h0000_0000, 6'd0);
    send_item(MODE_ALIGN, 32'hFFFF_FFFF, 6'd63);
    send_item(MODE_WRITE, 32'hFFFF_FF80, 6'd7);
    send_item(MODE_WRITE, 32'h0000_0001, 6'd1);
    send_item(MODE_WRITE, 32'hFFFF_FFFD, 6'd3);
    send_item(MODE_WRITE, 32'hA5A5_A5A5, 6'd32);
    send_item(MODE_WRITE, 32'h0000_001F, 6'd5);
    send_item(MODE_ALIGN, 32'hFFFF_FFFF, 6'd63);
    send_item(MODE_WRITE, 32'hFFFF_FFA5, 6'd8);
    send_item(MODE_WRITE, 32'h8000_0000, 6'd31);
    send_item(MODE_WRITE, 32'h0000_01FF, 6'd9);
    send_item(MODE_ALIGN, 32'h5555_5555, 6'd21);
    send_item(MODE_WRITE, 32'h0000_0003, 6'd2);
    send_item(MODE_WRITE, 32'h0000_0000, 6'd32);
    send_item(MODE_ALIGN, 32'h0000_0000, 6'd0);
    send_item(MODE_WRITE, 32'hFFFF_FFFF, 6'd63);
    send_item(MODE_WRITE, 32'h0000_0002, 6'd2);

    random_phase(120, 1'b1, SINK_MIXED);
    random_phase(120, 1'b0, SINK_FREE);
    // Let the pipeline run dry before the next burst.
    drain_output(8);
    random_phase(120, 1'b1, SINK_HEAVY);
    random_phase(120, 1'b1, SINK_MIXED);

    drain_output(10);

    $display("Covered %0d writes (%0d clamped, %0d of zero width)",
             n_writes, n_clamped, n_empty);
    $display("and %0d aligns (%0d with nothing pending); checked %0d bytes under back-pressure",
             n_aligns, n_idle_aligns, sb.bytes_checked);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
